// File: rtl/sdtw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdtw_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TRANSLATE_ENABLE = 3'd0;
    localparam logic [2:0] CFG_TABLE_BASE       = 3'd1;
    localparam logic [2:0] CFG_DOMAIN_CONTROL   = 3'd2;
    localparam logic [2:0] CFG_ROM_PROTECT      = 3'd3;
    localparam logic [2:0] CFG_SYSTEM_PROTECT   = 3'd4;

    // Input op codes
    localparam logic OP_TRANSLATE  = 1'b0;
    localparam logic OP_DESCRIPTOR = 1'b1;

    // Result kind
    localparam logic KIND_READ_REQ = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    // Result status
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FAULT  = 2'd1;
    localparam logic [1:0] STATUS_UNSUPP = 2'd2;

    // Fault class
    localparam logic [1:0] FCLASS_NONE  = 2'd0;
    localparam logic [1:0] FCLASS_READ  = 2'd1;
    localparam logic [1:0] FCLASS_WRITE = 2'd2;
    localparam logic [1:0] FCLASS_FETCH = 2'd3;

    // Access kind
    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_FETCH = 2'd2;

    // Descriptor type field, first level
    localparam logic [1:0] L1_FAULT   = 2'd0;
    localparam logic [1:0] L1_COARSE  = 2'd1;
    localparam logic [1:0] L1_SECTION = 2'd2;
    localparam logic [1:0] L1_FINE    = 2'd3;

    // Descriptor type field, second level
    localparam logic [1:0] L2_FAULT = 2'd0;
    localparam logic [1:0] L2_LARGE = 2'd1;
    localparam logic [1:0] L2_SMALL = 2'd2;
    localparam logic [1:0] L2_TINY  = 2'd3;

    // Fault status codes
    localparam logic [3:0] FSC_SECTION_XLATE  = 4'h5;
    localparam logic [3:0] FSC_PAGE_XLATE     = 4'h7;
    localparam logic [3:0] FSC_SECTION_DOMAIN = 4'h9;
    localparam logic [3:0] FSC_PAGE_DOMAIN    = 4'hb;
    localparam logic [3:0] FSC_SECTION_PERM   = 4'hd;
    localparam logic [3:0] FSC_PAGE_PERM      = 4'hf;
    localparam logic [3:0] FSC_NONE           = 4'h0;

    typedef enum logic [1:0] {
        CHK_PASS   = 2'd0,
        CHK_DOMAIN = 2'd1,
        CHK_PERM   = 2'd2
    } chk_t;

    typedef enum logic [3:0] {
        RES_NONE    = 4'd0,
        RES_REQ_L1  = 4'd1,
        RES_REQ_L2  = 4'd2,
        RES_PASS    = 4'd3,
        RES_SECTION = 4'd4,
        RES_LARGE   = 4'd5,
        RES_SMALL   = 4'd6,
        RES_FAULT   = 4'd7,
        RES_UNSUPP  = 4'd8
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       load_l1;
        res_sel_t   sel;
        logic [3:0] fcode;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       enable;
        logic [1:0] desc_type;
        chk_t       sec_chk;
        chk_t       page_chk;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/sdtw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sdtw_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     accept,
    input  wire                     op,
    input  sdtw_pkg::dp_status_t    dp_status,
    output sdtw_pkg::ctrl_cmd_t     cmd
);
    import sdtw_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    always_comb
    begin
        phase_next   = phase_reg;
        cmd.load_req = 1'b0;
        cmd.load_l1  = 1'b0;
        cmd.sel      = RES_NONE;
        cmd.fcode    = FSC_NONE;
        if (accept)
        begin
            if (op == OP_TRANSLATE)
            begin
                cmd.load_req = 1'b1;
                if (dp_status.enable)
                begin
                    cmd.sel    = RES_REQ_L1;
                    phase_next = PH_FIRST;
                end
                else
                begin
                    cmd.sel    = RES_PASS;
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        cmd.load_l1 = 1'b1;
                        phase_next  = PH_IDLE;
                        unique case (dp_status.desc_type)
                            L1_FAULT:
                            begin
                                cmd.sel   = RES_FAULT;
                                cmd.fcode = FSC_SECTION_XLATE;
                            end
                            L1_COARSE:
                            begin
                                cmd.sel    = RES_REQ_L2;
                                phase_next = PH_SECOND;
                            end
                            L1_SECTION:
                            begin
                                priority case (dp_status.sec_chk)
                                    CHK_DOMAIN:
                                    begin
                                        cmd.sel   = RES_FAULT;
                                        cmd.fcode = FSC_SECTION_DOMAIN;
                                    end
                                    CHK_PERM:
                                    begin
                                        cmd.sel   = RES_FAULT;
                                        cmd.fcode = FSC_SECTION_PERM;
                                    end
                                    default: cmd.sel = RES_SECTION;
                                endcase
                            end
                            default: cmd.sel = RES_UNSUPP;
                        endcase
                    end
                    PH_SECOND:
                    begin
                        phase_next = PH_IDLE;
                        if (dp_status.desc_type == L2_FAULT)
                        begin
                            cmd.sel   = RES_FAULT;
                            cmd.fcode = FSC_PAGE_XLATE;
                        end
                        else if (dp_status.page_chk == CHK_DOMAIN)
                        begin
                            cmd.sel   = RES_FAULT;
                            cmd.fcode = FSC_PAGE_DOMAIN;
                        end
                        else if (dp_status.page_chk == CHK_PERM)
                        begin
                            cmd.sel   = RES_FAULT;
                            cmd.fcode = FSC_PAGE_PERM;
                        end
                        else
                        begin
                            unique case (dp_status.desc_type)
                                L2_LARGE: cmd.sel = RES_LARGE;
                                L2_SMALL: cmd.sel = RES_SMALL;
                                default:  cmd.sel = RES_UNSUPP;
                            endcase
                        end
                    end
                    default:
                    begin
                        // drop descriptors that arrive with no walk open
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sdtw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sdtw_dp (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_write,
    input  wire [2:0]               cfg_index,
    input  wire [31:0]              cfg_data,
    input  wire [31:0]              virt_addr,
    input  wire [1:0]               access_kind,
    input  wire                     priv_access,
    input  wire                     record_fault,
    input  wire [31:0]              descriptor,
    input  sdtw_pkg::ctrl_cmd_t     cmd,
    output sdtw_pkg::dp_status_t    dp_status,
    output logic                    result_valid,
    output logic                    kind,
    output logic [31:0]             address,
    output logic [1:0]              status,
    output logic [1:0]              fault_class,
    output logic [7:0]              fault_status
);
    import sdtw_pkg::*;

    // configuration
    logic        enable_reg;
    logic [31:0] table_base_reg;
    logic [31:0] domain_control_reg;
    logic        rom_protect_reg;
    logic        system_protect_reg;

    // walk context
    logic [31:0] held_va_reg;
    logic [1:0]  held_ak_reg;
    logic        held_kernel_reg;
    logic        held_record_reg;
    logic [31:0] l1_word_reg;
    logic [7:0]  saved_fsr_reg;
    logic [31:0] saved_far_reg;

    // result
    logic        valid_reg;
    logic        kind_reg;
    logic [31:0] address_reg;
    logic [1:0]  status_reg;
    logic [1:0]  fclass_reg;
    logic [7:0]  fsr_reg;

    logic        kind_next;
    logic [31:0] address_next;
    logic [1:0]  status_next;
    logic [1:0]  fclass_next;
    logic [7:0]  fsr_next;
    logic [3:0]  fault_domain;
    logic        write_access;

    function automatic logic perm_ok(input logic [1:0] ap, input logic kern,
                                     input logic wr, input logic rom,
                                     input logic sys);
        logic ok;
        begin
            unique case (ap)
                2'd0:    ok = rom ? !wr : (sys ? (kern && !wr) : 1'b0);
                2'd1:    ok = kern;
                2'd2:    ok = kern || !wr;
                default: ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

    function automatic chk_t domain_chk(input logic [1:0] dac, input logic pass);
        chk_t r;
        begin
            if (dac == 2'd0)
                r = CHK_DOMAIN;
            else if (dac == 2'd1 && !pass)
                r = CHK_PERM;
            else
                r = CHK_PASS;
            return r;
        end
    endfunction

    assign write_access = (held_ak_reg == ACC_WRITE);

    // section check uses the incoming first-level word, page check the stored one
    assign dp_status.enable    = enable_reg;
    assign dp_status.desc_type = descriptor[1:0];
    assign dp_status.sec_chk   = domain_chk(
        domain_control_reg[{descriptor[8:5], 1'b0} +: 2],
        perm_ok(descriptor[11:10], held_kernel_reg, write_access,
                rom_protect_reg, system_protect_reg));
    assign dp_status.page_chk  = domain_chk(
        domain_control_reg[{l1_word_reg[8:5], 1'b0} +: 2],
        perm_ok(descriptor[5:4], held_kernel_reg, write_access,
                rom_protect_reg, system_protect_reg));

    assign fault_domain = cmd.load_l1 ? descriptor[8:5] : l1_word_reg[8:5];

    always_comb
    begin
        kind_next    = KIND_DONE;
        address_next = 32'd0;
        status_next  = STATUS_OK;
        fclass_next  = FCLASS_NONE;
        fsr_next     = 8'd0;
        unique case (cmd.sel)
            RES_REQ_L1:
            begin
                kind_next    = KIND_READ_REQ;
                address_next = {table_base_reg[31:14], virt_addr[31:20], 2'b00};
            end
            RES_REQ_L2:
            begin
                kind_next    = KIND_READ_REQ;
                address_next = {descriptor[31:10], held_va_reg[19:12], 2'b00};
            end
            RES_PASS:    address_next = virt_addr;
            RES_SECTION: address_next = {descriptor[31:20], held_va_reg[19:0]};
            RES_LARGE:   address_next = {descriptor[31:16], held_va_reg[15:0]};
            RES_SMALL:   address_next = {descriptor[31:12], held_va_reg[11:0]};
            RES_FAULT:
            begin
                status_next = STATUS_FAULT;
                fsr_next    = {fault_domain, cmd.fcode};
                if (held_ak_reg == ACC_WRITE)
                    fclass_next = FCLASS_WRITE;
                else if (held_ak_reg == ACC_FETCH)
                    fclass_next = FCLASS_FETCH;
                else
                    fclass_next = FCLASS_READ;
            end
            RES_UNSUPP:  status_next = STATUS_UNSUPP;
            default:     kind_next = KIND_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b0;
            table_base_reg     <= 32'd0;
            domain_control_reg <= 32'd0;
            rom_protect_reg    <= 1'b0;
            system_protect_reg <= 1'b0;
            held_va_reg        <= 32'd0;
            held_ak_reg        <= ACC_READ;
            held_kernel_reg    <= 1'b0;
            held_record_reg    <= 1'b0;
            l1_word_reg        <= 32'd0;
            saved_fsr_reg      <= 8'd0;
            saved_far_reg      <= 32'd0;
            valid_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TRANSLATE_ENABLE: enable_reg         <= cfg_data[0];
                    CFG_TABLE_BASE:       table_base_reg     <= cfg_data;
                    CFG_DOMAIN_CONTROL:   domain_control_reg <= cfg_data;
                    CFG_ROM_PROTECT:      rom_protect_reg    <= cfg_data[0];
                    CFG_SYSTEM_PROTECT:   system_protect_reg <= cfg_data[0];
                    default:              enable_reg         <= enable_reg;
                endcase
            end
            if (cmd.load_req)
            begin
                held_va_reg     <= virt_addr;
                // access kind three behaves as a read
                held_ak_reg     <= (access_kind == 2'd3) ? ACC_READ : access_kind;
                held_kernel_reg <= priv_access;
                held_record_reg <= record_fault;
            end
            if (cmd.load_l1)
            begin
                l1_word_reg <= descriptor;
            end
            if (cmd.sel == RES_FAULT && held_record_reg)
            begin
                saved_fsr_reg <= fsr_next;
                saved_far_reg <= held_va_reg;
            end
            valid_reg <= (cmd.sel != RES_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        address_reg <= address_next;
        status_reg  <= status_next;
        fclass_reg  <= fclass_next;
        fsr_reg     <= fsr_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign address      = address_reg;
    assign status       = status_reg;
    assign fault_class  = fclass_reg;
    assign fault_status = fsr_reg;

endmodule

`default_nettype wire

// File: rtl/short_descriptor_table_walker.sv
// A result appears on the result ports in the cycle after its request is accepted.
// Throughput: one request per cycle; busy stays low, since every step is a single
//   registered pass through the domain/permission check and the address merge.
// Reset (rst_n, asynchronous, active low): walk returns to idle, configuration,
//   walk context and kept fault status/address clear, result_valid drops.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module short_descriptor_table_walker (
    input  wire         clk,
    input  wire         rst_n,
    // configuration write port
    input  wire         cfg_write,
    input  wire [2:0]   cfg_index,
    input  wire [31:0]  cfg_data,
    // request side
    input  wire         start,
    output logic        busy,
    input  wire         op,
    input  wire [31:0]  virt_addr,
    input  wire [1:0]   access_kind,
    input  wire         priv_access,
    input  wire         record_fault,
    input  wire [31:0]  descriptor,
    // result side
    output logic        result_valid,
    output logic        kind,
    output logic [31:0] address,
    output logic [1:0]  status,
    output logic [1:0]  fault_class,
    output logic [7:0]  fault_status
);
    import sdtw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;
    logic       accept;

    // The walker never holds requests off: the controller decides the outcome
    // of each request in the cycle it arrives, and the datapath registers it.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Controller: tracks walk phase (idle, first-level, second-level) and
    // selects what each request produces: a descriptor read, a translated
    // address, a fault with its code, or an unsupported status.
    sdtw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Datapath: configuration registers, held request context, first-level
    // word, domain and AP checks, address merge and result registers.
    sdtw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .virt_addr    (virt_addr),
        .access_kind  (access_kind),
        .priv_access  (priv_access),
        .record_fault (record_fault),
        .descriptor   (descriptor),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .result_valid (result_valid),
        .kind         (kind),
        .address      (address),
        .status       (status),
        .fault_class  (fault_class),
        .fault_status (fault_status)
    );

endmodule

`default_nettype wire

// File: rtl/sdtw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdtw_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        cfg_write,
    input wire [2:0]  cfg_index,
    input wire [31:0] cfg_data,
    input wire        start,
    input wire        busy,
    input wire        op,
    input wire [31:0] virt_addr,
    input wire [1:0]  access_kind,
    input wire        priv_access,
    input wire        record_fault,
    input wire [31:0] descriptor,
    input wire        result_valid,
    input wire        kind,
    input wire [31:0] address,
    input wire [1:0]  status,
    input wire [1:0]  fault_class,
    input wire [7:0]  fault_status
);
    import sdtw_pkg::*;

    // every result traces back to a request taken the cycle before
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy))
        else $error("result without an accepted request");

    // a translate request always yields a result
    a_translate_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_TRANSLATE) |=> result_valid)
        else $error("translate request produced no result");

    // descriptor reads carry no status
    a_read_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_READ_REQ) |->
        (status == STATUS_OK && fault_class == FCLASS_NONE && fault_status == 8'd0))
        else $error("descriptor read request carries status");

    // faults report no address and always name a class
    a_fault_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_FAULT) |->
        (kind == KIND_DONE && address == 32'd0 && fault_class != FCLASS_NONE))
        else $error("malformed fault result");

endmodule

bind short_descriptor_table_walker sdtw_checker u_sdtw_checker (.*);

`default_nettype wire
